// File: rtl/priority_task_scheduler_defines.svh
// Assertion macros shared by the scheduler checker.
// Depends on nothing; include guarded.
`ifndef PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_DEFINES_SVH
// Implication checked on every clock, disabled in reset.
`define PTS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scheduler check failed");
// Next-cycle implication.
`define PTS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scheduler check failed");
`endif

// File: rtl/pts_pkg.sv
// Package for the priority task scheduler: beat types, codes, the entry record and the cell command.
// Depends on nothing.
`default_nettype none
package pts_pkg;
    localparam logic [3:0] REQ_ADD = 4'd0;
    localparam logic [3:0] REQ_SCHED = 4'd1;
    localparam logic [3:0] REQ_YIELD = 4'd2;
    localparam logic [3:0] REQ_BLOCK = 4'd3;
    localparam logic [3:0] REQ_SLEEP = 4'd4;
    localparam logic [3:0] REQ_WAKE = 4'd5;
    localparam logic [3:0] REQ_EXIT = 4'd6;
    localparam logic [3:0] REQ_TERM = 4'd7;
    localparam logic [3:0] REQ_EVICT = 4'd8;

    localparam logic [2:0] ST_READY = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_BLOCKED = 3'd3;
    localparam logic [2:0] ST_TERM = 3'd4;

    localparam logic [1:0] RES_DONE = 2'd0;
    localparam logic [1:0] RES_REFUSED = 2'd1;
    localparam logic [1:0] RES_FULL = 2'd2;
    localparam logic [1:0] RES_NONE = 2'd3;

    typedef struct packed {
        logic [3:0]  req_type;
        logic        core;
        logic [15:0] task_id;
        logic [15:0] priority_req;
        logic        kernel_task;
        logic [31:0] footprint;
        logic [31:0] ticks;
        logic [31:0] min_size;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] picked_id;
    } t_out_beat;

    typedef struct packed {
        logic        used;
        logic [15:0] id;
        logic [15:0] prio;
        logic        kernel;
        logic [2:0]  st;
        logic [31:0] wake;
        logic [31:0] size;
    } t_entry;

    // Operation driven into every cell in one cycle.
    localparam logic [2:0] OP_HOLD = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;  // write fields at index sel
    localparam logic [2:0] OP_INSERT = 3'd2; // shift up from sel, write new at sel
    localparam logic [2:0] OP_REMOVE = 3'd3; // shift down from sel
    localparam logic [2:0] OP_WAKE = 3'd4;   // all cells wake due sleepers

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  sel;
        logic        set_st;
        logic [2:0]  st;
        logic        set_wake;
        logic [31:0] wake;
        logic        set_size;
        logic [31:0] tick;
    } t_cell_cmd;
endpackage
`default_nettype wire

// File: rtl/pts_cell.sv
// One table slot: holds an entry and takes its neighbor's on shifts.
// Depends on pts_pkg.
`default_nettype none
module pts_cell #(
    parameter int IDX = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pts_pkg::t_cell_cmd  i_cmd,
    input  pts_pkg::t_entry     i_new,
    input  pts_pkg::t_entry     i_below,
    input  pts_pkg::t_entry     i_above,
    output pts_pkg::t_entry     o_entry
);
    import pts_pkg::*;
    t_entry r_e, n_e;
    logic hit, past;

    assign hit = (i_cmd.sel == 8'(IDX));
    assign past = (8'(IDX) > i_cmd.sel);

    // Next-value selection for this slot.
    always_comb begin
        n_e = r_e;
        case (i_cmd.op)
            OP_WRITE: begin
                if (hit) begin
                    if (i_cmd.set_st) n_e.st = i_cmd.st;
                    if (i_cmd.set_wake) n_e.wake = i_cmd.wake;
                    if (i_cmd.set_size) n_e.size = '0;
                end
            end
            OP_INSERT: begin
                if (hit) n_e = i_new;
                else if (past) n_e = i_below;
            end
            OP_REMOVE: begin
                if (hit || past) n_e = i_above;
            end
            OP_WAKE: begin
                if (r_e.used && r_e.st == ST_BLOCKED && r_e.wake != '0 &&
                    r_e.wake <= i_cmd.tick) begin
                    n_e.st = ST_READY;
                    n_e.wake = '0;
                end
            end
            default: ;
        endcase
    end

    // The slot empties on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e <= '0;
        else r_e <= n_e;
    end

    assign o_entry = r_e;
endmodule
`default_nettype wire

// File: rtl/priority_task_scheduler.sv
// Priority task scheduler, a chain of table cells walked by a sequencer.
// One request at a time; o_stall stays high until the result is loaded into the output register.
// Reset is synchronous, active low, and empties the table at once.
// Depends on pts_pkg and pts_cell.
`default_nettype none
module priority_task_scheduler #(
    parameter int TASK_SLOTS = 16,
    parameter int CORES = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  pts_pkg::t_in_beat   i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output pts_pkg::t_out_beat  o_data
);
    import pts_pkg::*;
    localparam int IW = $clog2(TASK_SLOTS + 1);
    localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;
    localparam logic [IW-1:0] NONE = IW'(TASK_SLOTS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;  // find position / match / best
    localparam logic [3:0] S_ACT = 4'd2;
    localparam logic [3:0] S_WAKE = 4'd3;
    localparam logic [3:0] S_TSCAN = 4'd4; // find terminated
    localparam logic [3:0] S_PICK = 4'd5;  // find ready
    localparam logic [3:0] S_OUT = 4'd6;
    localparam logic [3:0] S_PREP = 4'd7;
    localparam logic [3:0] S_SETTLE = 4'd8; // let a removal land in the cells

    t_entry cells [TASK_SLOTS+1];
    t_entry cell_out [TASK_SLOTS];
    t_cell_cmd cmd;
    t_entry new_e;

    logic [3:0] r_state;
    t_in_beat r_req;
    logic [IW-1:0] r_run [CORES];
    logic [IW-1:0] r_skip [CORES];
    logic [31:0] r_tick;
    logic [IW-1:0] r_i, r_found, r_alt;
    logic r_out_v;
    t_out_beat r_out;
    t_out_beat r_res;

    // Chain of cells; the slot above the top reads as empty.
    genvar g;
    for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
        pts_cell #(.IDX(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_new(new_e),
            .i_below((g == 0) ? cells[0] : cell_out[(g == 0) ? 0 : g-1]),
            .i_above(cells[g+1]), .o_entry(cell_out[g]));
        assign cells[g] = cell_out[g];
    end
    assign cells[TASK_SLOTS] = '0;

    logic core_ok;
    logic [CW-1:0] cidx;
    t_entry cur;
    logic [IW-1:0] run_c;
    assign cidx = CW'(r_req.core);
    assign core_ok = (32'(r_req.core) < CORES);
    assign cur = cells[r_i[IW-1:0] >= IW'(TASK_SLOTS) ? TASK_SLOTS : r_i];
    assign run_c = core_ok ? r_run[cidx] : NONE;

    always_comb begin
        new_e = '0;
        new_e.used = 1'b1;
        new_e.id = r_req.task_id;
        new_e.prio = r_req.priority_req;
        new_e.kernel = r_req.kernel_task;
        new_e.st = ST_READY;
        new_e.size = r_req.footprint;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_v;
    assign o_data = r_out;

    logic [IW-1:0] n_i;
    assign n_i = r_i + 1'b1;

    // Sequencer: one cell inspected per cycle.
    always_ff @(posedge i_clk) begin
        t_cell_cmd n_cmd;
        n_cmd = '0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick <= '0;
            r_out_v <= 1'b0;
            for (int c = 0; c < CORES; c++) begin
                r_run[c] <= NONE;
                r_skip[c] <= NONE;
            end
        end else begin
            if (r_out_v && !i_stall && r_state != S_OUT) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_data;
                        r_i <= '0;
                        r_found <= NONE;
                        r_alt <= NONE;
                        r_res.picked_id <= '0;
                        r_res.status <= RES_REFUSED;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_req.req_type != REQ_SCHED) r_state <= S_SCAN;
                    else if (!core_ok) r_state <= S_OUT;
                    else begin
                        if (run_c != NONE && cells[run_c].used) begin
                            n_cmd.op = OP_WRITE;
                            n_cmd.sel = 8'(run_c);
                            n_cmd.set_st = 1'b1;
                            n_cmd.st = ST_READY;
                            r_skip[cidx] <= run_c;
                        end
                        r_run[cidx] <= NONE;
                        r_tick <= r_tick + 32'd1;
                        r_state <= S_WAKE;
                    end
                end
                S_WAKE: begin
                    n_cmd.op = OP_WAKE;
                    n_cmd.tick = r_tick;
                    r_state <= S_TSCAN;
                end
                S_TSCAN: begin
                    if (r_i == NONE || !cur.used) begin
                        r_i <= '0;
                        r_state <= S_PICK;
                    end else if (cur.st == ST_TERM) begin
                        n_cmd.op = OP_REMOVE;
                        n_cmd.sel = 8'(r_i);
                        for (int c = 0; c < CORES; c++) begin
                            if (r_run[c] == r_i) r_run[c] <= NONE;
                            else if (r_run[c] != NONE && r_run[c] > r_i)
                                r_run[c] <= r_run[c] - 1'b1;
                            if (r_skip[c] == r_i) r_skip[c] <= NONE;
                            else if (r_skip[c] != NONE && r_skip[c] > r_i)
                                r_skip[c] <= r_skip[c] - 1'b1;
                        end
                        r_i <= '0;
                        r_state <= S_SETTLE;
                    end else r_i <= n_i;
                end
                S_SETTLE: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (r_i == NONE || !cur.used) begin
                        r_state <= S_ACT;
                    end else begin
                        if (cur.st == ST_READY) begin
                            if (r_alt == NONE) r_alt <= r_i;
                            if (r_skip[cidx] != r_i) begin
                                r_found <= r_i;
                                r_state <= S_ACT;
                            end
                        end
                        r_i <= n_i;
                    end
                end
                S_SCAN: begin
                    // Generic walk for every other request.
                    if (r_i == NONE || !cur.used) r_state <= S_ACT;
                    else begin
                        case (r_req.req_type)
                            REQ_ADD: begin
                                if (r_found == NONE && r_req.priority_req < cur.prio) begin
                                    r_found <= r_i;
                                    r_state <= S_ACT;
                                end
                            end
                            REQ_WAKE, REQ_TERM: begin
                                if (cur.id == r_req.task_id) begin
                                    r_found <= r_i;
                                    r_state <= S_ACT;
                                end
                            end
                            REQ_EVICT: begin
                                if (!cur.kernel && (cur.st == ST_READY ||
                                    cur.st == ST_BLOCKED) && cur.size >= r_req.min_size &&
                                    (r_found == NONE || cur.prio > cells[r_found].prio))
                                    r_found <= r_i;
                            end
                            default: r_state <= S_ACT;
                        endcase
                        r_i <= n_i;
                    end
                end
                S_ACT: begin
                    r_state <= S_OUT;
                    case (r_req.req_type)
                        REQ_ADD: begin
                            if (cells[TASK_SLOTS-1].used) r_res.status <= RES_FULL;
                            else begin
                                logic [IW-1:0] k;
                                k = (r_found == NONE) ? r_i : r_found;
                                n_cmd.op = OP_INSERT;
                                n_cmd.sel = 8'(k);
                                for (int c = 0; c < CORES; c++) begin
                                    if (r_run[c] != NONE && r_run[c] >= k)
                                        r_run[c] <= r_run[c] + 1'b1;
                                    if (r_skip[c] != NONE && r_skip[c] >= k)
                                        r_skip[c] <= r_skip[c] + 1'b1;
                                end
                                r_res.status <= RES_DONE;
                            end
                        end
                        REQ_SCHED: begin
                            logic [IW-1:0] s;
                            s = (r_found != NONE) ? r_found : r_alt;
                            if (s == NONE) r_res.status <= RES_NONE;
                            else begin
                                n_cmd.op = OP_WRITE;
                                n_cmd.sel = 8'(s);
                                n_cmd.set_st = 1'b1;
                                n_cmd.st = ST_RUNNING;
                                r_run[cidx] <= s;
                                r_skip[cidx] <= NONE;
                                r_res.status <= RES_DONE;
                                r_res.picked_id <= cells[s].id;
                            end
                        end
                        REQ_YIELD, REQ_BLOCK, REQ_SLEEP, REQ_EXIT: begin
                            if (run_c != NONE && cells[run_c].used) begin
                                n_cmd.op = OP_WRITE;
                                n_cmd.sel = 8'(run_c);
                                n_cmd.set_st = 1'b1;
                                case (r_req.req_type)
                                    REQ_YIELD: begin
                                        n_cmd.st = ST_READY;
                                        r_skip[cidx] <= run_c;
                                    end
                                    REQ_BLOCK: n_cmd.st = ST_BLOCKED;
                                    REQ_SLEEP: begin
                                        n_cmd.st = ST_BLOCKED;
                                        n_cmd.set_wake = 1'b1;
                                        n_cmd.wake = r_tick + r_req.ticks;
                                    end
                                    default: n_cmd.st = ST_TERM;
                                endcase
                                r_run[cidx] <= NONE;
                                r_res.status <= RES_DONE;
                            end
                        end
                        REQ_WAKE: begin
                            if (r_found != NONE) begin
                                r_res.status <= RES_DONE;
                                if (cells[r_found].st == ST_BLOCKED) begin
                                    n_cmd.op = OP_WRITE;
                                    n_cmd.sel = 8'(r_found);
                                    n_cmd.set_st = 1'b1;
                                    n_cmd.st = ST_READY;
                                    n_cmd.set_wake = 1'b1;
                                    n_cmd.wake = '0;
                                end
                            end
                        end
                        REQ_TERM: begin
                            if (r_found != NONE && !cells[r_found].kernel &&
                                cells[r_found].st != ST_RUNNING) begin
                                n_cmd.op = OP_WRITE;
                                n_cmd.sel = 8'(r_found);
                                n_cmd.set_st = 1'b1;
                                n_cmd.st = ST_TERM;
                                n_cmd.set_size = 1'b1;
                                r_res.status <= RES_DONE;
                            end
                        end
                        REQ_EVICT: begin
                            if (r_found != NONE) begin
                                r_res.status <= RES_DONE;
                                r_res.picked_id <= cells[r_found].id;
                                n_cmd.op = OP_REMOVE;
                                n_cmd.sel = 8'(r_found);
                                for (int c = 0; c < CORES; c++) begin
                                    if (r_run[c] == r_found) r_run[c] <= NONE;
                                    else if (r_run[c] != NONE && r_run[c] > r_found)
                                        r_run[c] <= r_run[c] - 1'b1;
                                    if (r_skip[c] == r_found) r_skip[c] <= NONE;
                                    else if (r_skip[c] != NONE && r_skip[c] > r_found)
                                        r_skip[c] <= r_skip[c] - 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    // Wait for the result register to free up.
                    if (!r_out_v || !i_stall) begin
                        r_out_v <= 1'b1;
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        cmd <= n_cmd;
    end
endmodule
`default_nettype wire

// File: rtl/pts_checker.sv
// Port-level checks for the priority task scheduler, bound to the top level.
// Depends on pts_pkg and the defines header.
`default_nettype none
`include "priority_task_scheduler_defines.svh"
module pts_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_valid,
    input wire                o_stall,
    input pts_pkg::t_out_beat o_data,
    input wire                o_valid,
    input wire                i_stall
);
    import pts_pkg::*;
    // A refused or failed result never names a task.
    `PTS_ASSERT_IMP(a_pick_zero, i_clk, i_rst_n, o_valid && o_data.status != RES_DONE, o_data.picked_id == 16'd0)
    // An accepted beat keeps the scheduler busy in the next cycle.
    `PTS_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // A stalled result holds.
    `PTS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
endmodule
bind priority_task_scheduler pts_checker u_pts_checker (.*);
`default_nettype wire
